// ----- src/blecec_pkg.sv -----
// ----------------------------------------------------------------------------
// blecec_pkg: shared types and constants of the connection-event controller
// Command codes, host packet kinds, register indexes and timing constants.
// ----------------------------------------------------------------------------
package blecec_pkg;

  // Input command carried in in_tuser
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_RX    = 2'd1,
    CMD_HOST  = 2'd2,
    CMD_START = 2'd3
  } cmd_t;

  // Host packet kinds; the unused code is handled as plain data
  localparam logic [1:0] PDU_PLAIN   = 2'd0;
  localparam logic [1:0] PDU_CONNUPD = 2'd1;
  localparam logic [1:0] PDU_CHANMAP = 2'd2;

  // Configuration register indexes
  localparam logic CFG_ACK_ENABLE     = 1'b0;
  localparam logic CFG_AUTO_EMPTY_PDU = 1'b1;

  // Timing constants in microseconds
  localparam int unsigned UNIT_US        = 1250;
  localparam int unsigned START_EXTRA_US = 300;

  localparam int unsigned TIMER_W = 27;
  localparam int unsigned MAP_W   = 40;

  // One result item
  typedef struct packed {
    logic               rx_accepted;
    logic [MAP_W-1:0]   map_out;
    logic               map_applied;
    logic               hop;
    logic [TIMER_W-1:0] timer_us;
    logic [15:0]        event_number;
    logic               nesn_bit;
    logic               sn_bit;
    logic               send_empty;
    logic               transmit;
  } result_t;

endpackage

// ----- src/ble_connection_event_controller_core.sv -----
// ----------------------------------------------------------------------------
// ble_connection_event_controller_core: BLE link-layer connection events
// Master-side event bookkeeping with SN/NESN acknowledgement and updates.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on the in_ stream: in_tuser selects the command (event
//   tick, received packet, host packet, connection start) and the host packet
//   kind; in_tdata carries the NESN bit, instant, interval, window offset and
//   channel map. Every accepted item yields exactly one result on the out_
//   stream: transmit/empty/SN/NESN flags, event number, next timer period,
//   hop pulse, channel map in use and the receive acceptance flag.
//   The result is loaded into the output register at the transfer edge and
//   offered from the next cycle on. Throughput is one item per cycle while
//   the receiver takes results; the whole update is a single pass through
//   one 16x11 multiplier and an adder.
//   The input is taken whenever the output register is empty or is being
//   drained in the same cycle, so a stalled receiver holds the result and
//   stops the input only while the output register stays full.
//   Reset (rst_n low, synchronous) clears all connection state, drops any
//   held result and sets ack_enable and auto_empty_pdu to 1. The user makes
//   configuration writes (cfg_wr_en) only with no item in flight, unenforced.
// ----------------------------------------------------------------------------
module ble_connection_event_controller_core
  import blecec_pkg::*;
#(
  parameter int MAX_RETRIES = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,  // rx_nesn[0], instant[16:1], interval[32:17],
                                 // tw_offset[48:33], map_bits[88:49], zero
  input  logic [3:0]  in_tuser,  // command[1:0], pdu_kind[3:2]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata, // transmit[0], send_empty[1], sn_bit[2],
                                 // nesn_bit[3], event_number[19:4],
                                 // timer_us[46:20], hop[47], map_applied[48],
                                 // map_out[88:49], rx_accepted[89], zero
  // configuration
  input  logic        cfg_wr_en,
  input  logic        cfg_addr,
  input  logic        cfg_wdata
);

  localparam logic [2:0] MaxRetryCnt = 3'(MAX_RETRIES);

  // Unpack input fields
  cmd_t             command;
  logic [1:0]       pdu_kind;
  logic             rx_nesn;
  logic [15:0]      instant;
  logic [15:0]      interval;
  logic [15:0]      tw_offset;
  logic [MAP_W-1:0] map_bits;

  assign command   = cmd_t'(in_tuser[1:0]);
  assign pdu_kind  = in_tuser[3:2];
  assign rx_nesn   = in_tdata[0];
  assign instant   = in_tdata[16:1];
  assign interval  = in_tdata[32:17];
  assign tw_offset = in_tdata[48:33];
  assign map_bits  = in_tdata[88:49];

  // Configuration registers
  logic ack_enable_r, auto_empty_pdu_r;

  // Connection state
  logic             connected_r,     connected_nxt;
  logic [15:0]      event_counter_r, event_counter_nxt;
  logic [15:0]      cur_interval_r,  cur_interval_nxt;
  logic [15:0]      cur_offset_r,    cur_offset_nxt;
  logic [MAP_W-1:0] cur_map_r,       cur_map_nxt;
  logic             upd_pending_r,   upd_pending_nxt;
  logic [15:0]      upd_instant_r,   upd_instant_nxt;
  logic [15:0]      upd_interval_r,  upd_interval_nxt;
  logic [15:0]      upd_offset_r,    upd_offset_nxt;
  logic             map_pending_r,   map_pending_nxt;
  logic [15:0]      map_instant_r,   map_instant_nxt;
  logic [MAP_W-1:0] new_map_r,       new_map_nxt;
  logic             data_pending_r,  data_pending_nxt;
  logic [2:0]       retry_count_r,   retry_count_nxt;
  logic             seq_num_r,       seq_num_nxt;
  logic             next_expected_r, next_expected_nxt;

  // Output register
  logic    out_valid_r, out_valid_nxt;
  result_t res_r,       res_nxt;

  logic in_fire;
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  // Timer multiplier operands
  logic [15:0]        mul_op;
  logic [TIMER_W-1:0] mul_add;
  logic [TIMER_W-1:0] timer_val;
  logic               timer_en;
  logic               upd_hit, map_hit;

  assign upd_hit = upd_pending_r && (event_counter_r == upd_instant_r);
  assign map_hit = map_pending_r && (event_counter_r == map_instant_r);

  // Select timer operand: start uses the new offset, update instant the
  // updated offset, a normal event the current interval
  always_comb begin
    mul_op   = cur_interval_r;
    mul_add  = '0;
    timer_en = 1'b0;
    unique case (command)
      CMD_START: begin
        mul_op   = tw_offset;
        mul_add  = TIMER_W'(UNIT_US + START_EXTRA_US);
        timer_en = (interval != 16'd0);
      end
      CMD_TICK: begin
        timer_en = connected_r;
        if (upd_hit) begin
          mul_op  = upd_offset_r;
          mul_add = TIMER_W'(UNIT_US);
        end
      end
      default: begin
        timer_en = 1'b0;
      end
    endcase
  end

  assign timer_val = TIMER_W'(mul_op * 11'(UNIT_US)) + mul_add;

  // Next state and result of one item
  always_comb begin
    connected_nxt     = connected_r;
    event_counter_nxt = event_counter_r;
    cur_interval_nxt  = cur_interval_r;
    cur_offset_nxt    = cur_offset_r;
    cur_map_nxt       = cur_map_r;
    upd_pending_nxt   = upd_pending_r;
    upd_instant_nxt   = upd_instant_r;
    upd_interval_nxt  = upd_interval_r;
    upd_offset_nxt    = upd_offset_r;
    map_pending_nxt   = map_pending_r;
    map_instant_nxt   = map_instant_r;
    new_map_nxt       = new_map_r;
    data_pending_nxt  = data_pending_r;
    retry_count_nxt   = retry_count_r;
    seq_num_nxt       = seq_num_r;
    next_expected_nxt = next_expected_r;
    res_nxt           = '0;
    res_nxt.timer_us  = timer_en ? timer_val : '0;

    unique case (command)
      // Load a new connection; zero interval is ignored
      CMD_START: begin
        if (interval != 16'd0) begin
          cur_interval_nxt  = interval;
          cur_offset_nxt    = tw_offset;
          cur_map_nxt       = map_bits;
          connected_nxt     = 1'b1;
          event_counter_nxt = '0;
        end
      end
      // Record update requests; queue data only when connected
      CMD_HOST: begin
        if (pdu_kind == PDU_CONNUPD) begin
          upd_instant_nxt  = instant;
          upd_interval_nxt = interval;
          upd_offset_nxt   = tw_offset;
          upd_pending_nxt  = 1'b1;
        end else if (pdu_kind == PDU_CHANMAP) begin
          map_instant_nxt = instant;
          new_map_nxt     = map_bits;
          map_pending_nxt = 1'b1;
        end
        if (connected_r) begin
          data_pending_nxt = 1'b1;
          retry_count_nxt  = '0;
        end
      end
      // Drop duplicates by NESN; a new NESN acknowledges queued data
      CMD_RX: begin
        res_nxt.rx_accepted = 1'b1;
        if (connected_r && ack_enable_r) begin
          if (rx_nesn == next_expected_r) begin
            res_nxt.rx_accepted = 1'b0;
          end else begin
            data_pending_nxt  = 1'b0;
            next_expected_nxt = rx_nesn;
            seq_num_nxt       = rx_nesn;
          end
        end
      end
      // Event tick: apply updates at their instant; run the event unless a connection update is applied
      CMD_TICK: begin
        if (connected_r) begin
          if (upd_hit) begin
            upd_pending_nxt  = 1'b0;
            cur_interval_nxt = upd_interval_r;
            cur_offset_nxt   = upd_offset_r;
          end
          if (map_hit) begin
            map_pending_nxt     = 1'b0;
            cur_map_nxt         = new_map_r;
            res_nxt.map_applied = 1'b1;
          end
          if (!upd_hit) begin
            event_counter_nxt = event_counter_r + 16'd1;
            res_nxt.hop       = 1'b1;
            if (data_pending_r) begin
              res_nxt.transmit = 1'b1;
              if (ack_enable_r) begin
                if ((retry_count_r <= MaxRetryCnt) && (retry_count_r != 3'd7)) begin
                  retry_count_nxt = retry_count_r + 3'd1;
                end else begin
                  retry_count_nxt  = '0;
                  data_pending_nxt = 1'b0;
                end
              end
            end else if (auto_empty_pdu_r) begin
              res_nxt.transmit   = 1'b1;
              res_nxt.send_empty = 1'b1;
            end
            if (res_nxt.transmit) begin
              if (ack_enable_r) begin
                res_nxt.sn_bit   = seq_num_r;
                res_nxt.nesn_bit = next_expected_r;
              end else begin
                data_pending_nxt = 1'b0;
              end
            end
          end
        end
      end
      default: begin
        res_nxt.timer_us = '0;
      end
    endcase

    res_nxt.event_number = event_counter_nxt;
    res_nxt.map_out      = cur_map_nxt;
  end

  // Hold result until taken, load on each input transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control and connection state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_enable_r     <= 1'b1;
      auto_empty_pdu_r <= 1'b1;
      out_valid_r      <= 1'b0;
      connected_r      <= 1'b0;
      event_counter_r  <= '0;
      cur_interval_r   <= '0;
      cur_offset_r     <= '0;
      cur_map_r        <= '0;
      upd_pending_r    <= 1'b0;
      upd_instant_r    <= '0;
      upd_interval_r   <= '0;
      upd_offset_r     <= '0;
      map_pending_r    <= 1'b0;
      map_instant_r    <= '0;
      new_map_r        <= '0;
      data_pending_r   <= 1'b0;
      retry_count_r    <= '0;
      seq_num_r        <= 1'b0;
      next_expected_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          CFG_ACK_ENABLE:     ack_enable_r     <= cfg_wdata;
          CFG_AUTO_EMPTY_PDU: auto_empty_pdu_r <= cfg_wdata;
          default:            ack_enable_r     <= ack_enable_r;
        endcase
      end
      if (in_fire) begin
        connected_r     <= connected_nxt;
        event_counter_r <= event_counter_nxt;
        cur_interval_r  <= cur_interval_nxt;
        cur_offset_r    <= cur_offset_nxt;
        cur_map_r       <= cur_map_nxt;
        upd_pending_r   <= upd_pending_nxt;
        upd_instant_r   <= upd_instant_nxt;
        upd_interval_r  <= upd_interval_nxt;
        upd_offset_r    <= upd_offset_nxt;
        map_pending_r   <= map_pending_nxt;
        map_instant_r   <= map_instant_nxt;
        new_map_r       <= new_map_nxt;
        data_pending_r  <= data_pending_nxt;
        retry_count_r   <= retry_count_nxt;
        seq_num_r       <= seq_num_nxt;
        next_expected_r <= next_expected_nxt;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  // Pack result fields, highest first
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0,
                       res_r.rx_accepted,
                       res_r.map_out,
                       res_r.map_applied,
                       res_r.hop,
                       res_r.timer_us,
                       res_r.event_number,
                       res_r.nesn_bit,
                       res_r.sn_bit,
                       res_r.send_empty,
                       res_r.transmit};

  // A sent packet always comes with a channel hop
  a_tx_hop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_r.transmit |-> res_r.hop)
    else $error("transmit without hop");

  // Empty PDU only when a packet is sent
  a_empty_tx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_r.send_empty |-> res_r.transmit)
    else $error("empty PDU flag without transmit");

  // An empty output register never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output register");

  // The retry counter moves only while data is queued or being dropped
  a_retry_range: assert property (@(posedge clk) disable iff (!rst_n)
    !data_pending_r && $past(!data_pending_r) && $past(rst_n) |-> $stable(retry_count_r))
    else $error("retry counter moved with no queued data");

endmodule
